// ===== rtl/core/gf2_four_russians_row_multiply_macros.svh =====
// ----------------------------------------------------------------------------
// gf2 four russians row multiply - assertion macros
// concurrent assertion helpers, empty when building for synthesis
// ----------------------------------------------------------------------------
`ifndef GF2_FOUR_RUSSIANS_ROW_MULTIPLY_MACROS_SVH
`define GF2_FOUR_RUSSIANS_ROW_MULTIPLY_MACROS_SVH

`ifndef SYNTHESIS

// implication or plain property, sampled on the rising clock edge
`define GF2FR_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
		else $error("gf2fr assertion failed");

// condition that must never be true
`define GF2FR_NEVER(lbl, clk, rstn, cond) \
	`GF2FR_ASSERT(lbl, clk, rstn, !(cond))

`else

`define GF2FR_ASSERT(lbl, clk, rstn, prop)
`define GF2FR_NEVER(lbl, clk, rstn, cond)

`endif

`endif

// ===== rtl/core/gf2fr_pkg.sv =====
// ----------------------------------------------------------------------------
// gf2fr_pkg
// shared constants, types and helpers of the gf2 four russians row multiply
// ----------------------------------------------------------------------------
`default_nettype none

package gf2fr_pkg;

	localparam int ROW_W      = 64;
	localparam int SLICE_BITS = 6;
	localparam int NUM_TABLES = 11;
	localparam int ENTRIES    = 1 << SLICE_BITS;

	// slices that actually start inside the row
	localparam int ROW_SLICES = (ROW_W + SLICE_BITS - 1) / SLICE_BITS;
	localparam int LOOKUPS    = (NUM_TABLES < ROW_SLICES) ? NUM_TABLES : ROW_SLICES;

	localparam int SEL_W   = 4;
	localparam int ENTRY_W = 6;
	localparam int MODE_W  = 2;

	// input tdata layout, lowest field first
	localparam int SEL_LSB   = 0;
	localparam int ENTRY_LSB = SEL_LSB + SEL_W;
	localparam int WORD_LSB  = ENTRY_LSB + ENTRY_W;
	localparam int AROW_LSB  = WORD_LSB + ROW_W;
	localparam int PRIOR_LSB = AROW_LSB + ROW_W;
	localparam int IN_BITS   = PRIOR_LSB + ROW_W;
	localparam int IN_DATA_W = ((IN_BITS + 7) / 8) * 8;

	// output queue
	localparam int OUTQ_DEPTH = 4;
	localparam int OUTQ_PTR_W = $clog2(OUTQ_DEPTH);
	localparam int OUTQ_LVL_W = $clog2(OUTQ_DEPTH + 1);

	typedef logic [ROW_W-1:0]      row_t;
	typedef logic [SLICE_BITS-1:0] addr_t;

	typedef enum logic [MODE_W-1:0] {
		MODE_WRITE  = 2'd0,
		MODE_ASSIGN = 2'd1,
		MODE_ACCUM  = 2'd2
	} mode_t;

	typedef struct packed {
		row_t product;
		logic last;
	} result_t;

	// lookup address of slice t, bits past the row read as zero
	function automatic addr_t slice_of(input row_t row, input int unsigned t);
		row_t tmp;
		tmp = row >> (t * SLICE_BITS);
		return tmp[SLICE_BITS-1:0];
	endfunction

	// table entry field cut or extended to the slice width
	function automatic addr_t entry_addr(input logic [ENTRY_W-1:0] e);
		logic [SLICE_BITS+ENTRY_W-1:0] w;
		w = {{SLICE_BITS{1'b0}}, e};
		return w[SLICE_BITS-1:0];
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/gf2_four_russians_row_multiply.sv =====
// ----------------------------------------------------------------------------
// gf2_four_russians_row_multiply
// gf(2) row times 64x64 matrix through banked four russians slice tables
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake          payload
//  --------  ---  -----------------  ------------------------------------------
//  s_*       in   s_tvalid/s_tready  s_tuser mode, s_tdata table and row fields,
//                                    s_tlast row_last
//  m_*       out  m_tvalid/m_tready  m_tdata product_row, m_tlast last_row
//
//  one item per cycle while s_tready is high, each slice table in its own bank
//  a row's product enters the output queue at the edge after its transfer,
//  via the bank read and lookup stage, and leaves once it heads the queue and m_tready is high
//  a table write lands at its accept edge, so a row right behind it sees it
//  s_tready drops while queue level plus lookup stage reach the depth (four)
//  reset clears control only; table contents are undefined until written
// ----------------------------------------------------------------------------
`default_nettype none
`include "gf2_four_russians_row_multiply_macros.svh"

module gf2_four_russians_row_multiply (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// slave side
	input  wire logic                                s_tvalid,
	output logic                                     s_tready,
	// table_select[3:0], table_entry[9:4], table_word[73:10], a_row[137:74],
	// prior_row[201:138], zero pad
	input  wire logic [gf2fr_pkg::IN_DATA_W-1:0]     s_tdata,
	// mode[1:0]
	input  wire logic [gf2fr_pkg::MODE_W-1:0]        s_tuser,
	input  wire logic                                s_tlast,
	// master side
	output logic                                     m_tvalid,
	input  wire logic                                m_tready,
	// product_row[63:0]
	output logic [gf2fr_pkg::ROW_W-1:0]              m_tdata,
	output logic                                     m_tlast
);

	// input field split
	logic [gf2fr_pkg::SEL_W-1:0]   table_select;
	logic [gf2fr_pkg::ENTRY_W-1:0] table_entry;
	gf2fr_pkg::row_t               table_word;
	gf2fr_pkg::row_t               a_row;
	gf2fr_pkg::row_t               prior_row;

	assign table_select = s_tdata[gf2fr_pkg::SEL_LSB   +: gf2fr_pkg::SEL_W];
	assign table_entry  = s_tdata[gf2fr_pkg::ENTRY_LSB +: gf2fr_pkg::ENTRY_W];
	assign table_word   = s_tdata[gf2fr_pkg::WORD_LSB  +: gf2fr_pkg::ROW_W];
	assign a_row        = s_tdata[gf2fr_pkg::AROW_LSB  +: gf2fr_pkg::ROW_W];
	assign prior_row    = s_tdata[gf2fr_pkg::PRIOR_LSB +: gf2fr_pkg::ROW_W];

	// transfer decode
	logic s_xfer;
	logic row_xfer;
	logic wr_xfer;
	logic sel_ok;

	assign s_xfer   = s_tvalid && s_tready;
	assign row_xfer = s_xfer && ((s_tuser == gf2fr_pkg::MODE_ASSIGN) ||
	                             (s_tuser == gf2fr_pkg::MODE_ACCUM));
	// writes to tables whose slice lies past the row are dropped, never read
	assign sel_ok   = (32'(table_select) < 32'(gf2fr_pkg::LOOKUPS));
	assign wr_xfer  = s_xfer && (s_tuser == gf2fr_pkg::MODE_WRITE) && sel_ok;

	// slice table banks
	gf2fr_pkg::row_t  bank_rdata [gf2fr_pkg::LOOKUPS];
	gf2fr_pkg::addr_t wr_addr;

	assign wr_addr = gf2fr_pkg::entry_addr(table_entry);

	for (genvar t = 0; t < gf2fr_pkg::LOOKUPS; t++) begin : g_bank
		gf2fr_bank u_bank (
			.clk   (clk),
			.we    (wr_xfer && (32'(table_select) == 32'(t))),
			.waddr (wr_addr),
			.wdata (table_word),
			.re    (row_xfer),
			.raddr (gf2fr_pkg::slice_of(a_row, t)),
			.rdata (bank_rdata[t])
		);
	end

	// lookup stage, aligned with the bank read data
	logic            valid_s1;
	logic            accum_s1;
	logic            last_s1;
	gf2fr_pkg::row_t prior_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= row_xfer;
		end
	end

	always_ff @(posedge clk) begin
		if (row_xfer) begin
			accum_s1 <= (s_tuser == gf2fr_pkg::MODE_ACCUM);
			last_s1  <= s_tlast;
			prior_s1 <= prior_row;
		end
	end

	// xor of all looked-up words, prior row folded in for accumulate
	gf2fr_pkg::row_t    product;
	gf2fr_pkg::result_t res;

	always_comb begin
		product = accum_s1 ? prior_s1 : '0;
		for (int t = 0; t < gf2fr_pkg::LOOKUPS; t++) begin
			product = product ^ bank_rdata[t];
		end
		res.product = product;
		res.last    = last_s1;
	end

	// output queue and credit
	gf2fr_pkg::result_t                 out_res;
	logic [gf2fr_pkg::OUTQ_LVL_W-1:0]   q_level;
	logic [gf2fr_pkg::OUTQ_LVL_W:0]     in_flight;

	gf2fr_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (valid_s1),
		.push_data (res),
		.pop_ready (m_tready),
		.out_valid (m_tvalid),
		.out_data  (out_res),
		.level     (q_level)
	);

	assign in_flight = {1'b0, q_level} + {{gf2fr_pkg::OUTQ_LVL_W{1'b0}}, valid_s1};
	assign s_tready  = (in_flight < (gf2fr_pkg::OUTQ_LVL_W + 1)'(gf2fr_pkg::OUTQ_DEPTH));
	assign m_tdata   = out_res.product;
	assign m_tlast   = out_res.last;

	// checks
	`GF2FR_ASSERT(a_row_reaches_s1, clk, arst_n, row_xfer |=> valid_s1)
	`GF2FR_NEVER(a_queue_overflow, clk, arst_n,
		valid_s1 && (32'(q_level) == 32'(gf2fr_pkg::OUTQ_DEPTH)) && !m_tready)
	`GF2FR_ASSERT(a_write_no_result, clk, arst_n, (s_xfer && !row_xfer) |=> !valid_s1)

endmodule

`default_nettype wire

// ===== rtl/core/gf2fr_bank.sv =====
// ----------------------------------------------------------------------------
// gf2fr_bank
// one slice table: single write port, registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module gf2fr_bank (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire gf2fr_pkg::addr_t  waddr,
	input  wire gf2fr_pkg::row_t   wdata,
	input  wire logic              re,
	input  wire gf2fr_pkg::addr_t  raddr,
	output gf2fr_pkg::row_t        rdata
);

	gf2fr_pkg::row_t mem [gf2fr_pkg::ENTRIES];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/gf2fr_outq.sv =====
// ----------------------------------------------------------------------------
// gf2fr_outq
// small result queue between the lookup stage and the master port
// ----------------------------------------------------------------------------
`default_nettype none

module gf2fr_outq (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                push,
	input  wire gf2fr_pkg::result_t                  push_data,
	input  wire logic                                pop_ready,
	output logic                                     out_valid,
	output gf2fr_pkg::result_t                       out_data,
	output logic [gf2fr_pkg::OUTQ_LVL_W-1:0]         level
);

	gf2fr_pkg::result_t                   slot_q [gf2fr_pkg::OUTQ_DEPTH];
	logic [gf2fr_pkg::OUTQ_PTR_W-1:0]     wr_ptr_q;
	logic [gf2fr_pkg::OUTQ_PTR_W-1:0]     rd_ptr_q;
	logic [gf2fr_pkg::OUTQ_LVL_W-1:0]     count_q;
	logic                                 pop;

	assign out_valid = (count_q != '0);
	assign out_data  = slot_q[rd_ptr_q];
	assign pop       = out_valid && pop_ready;
	assign level     = count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench - gf2 four russians row multiply
// streams table writes and row products through the block, predicts each
// product from a local copy of the slice tables and checks every output
// transfer in order, with random idling on both sides
// ----------------------------------------------------------------------------

module testbench;

	import gf2fr_pkg::*;

	localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
	localparam int RANDOM_ITEMS = 700;
	localparam int DRAIN_CYCLES = 16;

	typedef struct {
		logic [MODE_W-1:0]  mode;
		logic [SEL_W-1:0]   sel;
		logic [ENTRY_W-1:0] entry;
		row_t               word;
		row_t               a_row;
		row_t               prior;
		logic               last;
	} bus_item_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [IN_DATA_W-1:0] s_tdata = '0;
	logic [MODE_W-1:0]    s_tuser = '0;
	logic                 s_tlast = 1'b0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [ROW_W-1:0]     m_tdata;
	logic                 m_tlast;

	// stimulus waiting for the driver, in order
	bus_item_t stim_items[$];
	// products still owed by the block, oldest first
	result_t   pending_products[$];
	// local copy of the slice tables, updated at each accepted write
	row_t      slice_copy[NUM_TABLES][ENTRIES];
	// entries the generator has written and a row can legally read
	bit        gen_written[NUM_TABLES][ENTRIES];
	int        gen_readable[NUM_TABLES][$];

	bus_item_t cur_item;
	int        cycle_cnt = 0;
	int        errors = 0;

	gf2_four_russians_row_multiply dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
	end

	// random idle, except over a long recurring stretch with no idling at all
	function automatic bit idle_now();
		if ((cycle_cnt % 1000) >= 600 && (cycle_cnt % 1000) < 900)
			return 1'b0;
		return $urandom_range(99) < 20;
	endfunction

	function automatic row_t rand_row();
		case ($urandom_range(15))
			0: return '0;
			1: return '1;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	// entries of table t a row can reach; the top slice is narrower
	function automatic int readable_limit(input int t);
		int remaining;
		remaining = ROW_W - t * SLICE_BITS;
		if (remaining <= 0)
			return 0;
		return 1 << ((remaining < SLICE_BITS) ? remaining : SLICE_BITS);
	endfunction

	// xor of the table words picked by each slice of the row
	function automatic row_t gf2_row_product(input row_t a_row);
		row_t acc;
		int   shift;
		int   idx;
		acc = '0;
		for (int t = 0; t < NUM_TABLES; t++) begin
			shift = t * SLICE_BITS;
			if (shift >= ROW_W)
				break;
			idx = int'((a_row >> shift) & row_t'(ENTRIES - 1));
			acc ^= slice_copy[t][idx];
		end
		return acc;
	endfunction

	// predictor: apply one accepted transfer to the table copy or owe a product
	task automatic take_item(input bus_item_t it);
		result_t res;
		if (it.mode == MODE_WRITE) begin
			if (it.sel < NUM_TABLES)
				slice_copy[it.sel][it.entry & (ENTRIES - 1)] = it.word;
		end else if (it.mode == MODE_ASSIGN || it.mode == MODE_ACCUM) begin
			res.product = gf2_row_product(it.a_row);
			if (it.mode == MODE_ACCUM)
				res.product ^= it.prior;
			res.last = it.last;
			pending_products.push_back(res);
		end
	endtask

	function automatic bus_item_t rand_item();
		bus_item_t it;
		it.mode  = MODE_W'($urandom_range(3));
		it.sel   = SEL_W'($urandom);
		it.entry = ENTRY_W'($urandom);
		it.word  = rand_row();
		it.a_row = rand_row();
		it.prior = rand_row();
		it.last  = 1'($urandom_range(1));
		return it;
	endfunction

	task automatic queue_write(input int sel, input int entry, input row_t word);
		bus_item_t it;
		int        e;
		it = rand_item();
		it.mode  = MODE_WRITE;
		it.sel   = SEL_W'(sel);
		it.entry = ENTRY_W'(entry);
		it.word  = word;
		stim_items.push_back(it);
		if (sel < NUM_TABLES) begin
			e = entry & (ENTRIES - 1);
			if (e < readable_limit(sel) && !gen_written[sel][e]) begin
				gen_written[sel][e] = 1'b1;
				gen_readable[sel].push_back(e);
			end
		end
	endtask

	task automatic queue_row(input logic [MODE_W-1:0] mode, input row_t a_row,
			input row_t prior, input logic last);
		bus_item_t it;
		it = rand_item();
		it.mode  = mode;
		it.a_row = a_row;
		it.prior = prior;
		it.last  = last;
		stim_items.push_back(it);
	endtask

	// row whose every slice lands on a written entry
	function automatic row_t row_from_written();
		row_t a_row;
		int   pick;
		a_row = '0;
		for (int t = 0; t < NUM_TABLES; t++) begin
			if (readable_limit(t) == 0)
				break;
			pick = gen_readable[t][$urandom_range(gen_readable[t].size() - 1)];
			a_row |= row_t'(pick) << (t * SLICE_BITS);
		end
		return a_row;
	endfunction

	// driver: present queued items, predict each one at its accept edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			s_tuser  <= '0;
			s_tlast  <= 1'b0;
		end else begin
			if (s_tvalid && s_tready)
				take_item(cur_item);
			if (!s_tvalid || s_tready) begin
				if (stim_items.size() != 0 && !idle_now()) begin
					cur_item = stim_items.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= IN_DATA_W'({cur_item.prior, cur_item.a_row,
						cur_item.word, cur_item.entry, cur_item.sel});
					s_tuser  <= cur_item.mode;
					s_tlast  <= cur_item.last;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// sink side back-pressure
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tready <= 1'b0;
		else
			m_tready <= !idle_now();
	end

	// monitor: each output transfer against the oldest owed product
	always @(posedge clk) begin
		result_t exp_res;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_products.size() == 0) begin
				$display("%0t: unexpected output transfer, product %h last %b",
					$time, m_tdata, m_tlast);
				errors++;
			end else begin
				exp_res = pending_products.pop_front();
				if (m_tdata !== exp_res.product) begin
					$display("%0t: product_row expected %h actual %h",
						$time, exp_res.product, m_tdata);
					errors++;
				end
				if (m_tlast !== exp_res.last) begin
					$display("%0t: last_row expected %b actual %b",
						$time, exp_res.last, m_tlast);
					errors++;
				end
			end
		end
	end

	initial begin
		int   roll;
		row_t w;
		for (int t = 0; t < NUM_TABLES; t++)
			for (int e = 0; e < ENTRIES; e++) begin
				slice_copy[t][e]  = '0;
				gen_written[t][e] = 1'b0;
			end

		// directed: top entry of every table, so an all-ones row is legal
		for (int t = 0; t < NUM_TABLES; t++) begin
			w = (t == 0) ? '1 : (t == 1) ? '0 : {$urandom, $urandom};
			queue_write(t, readable_limit(t) - 1, w);
		end
		queue_row(MODE_ASSIGN, '1, {$urandom, $urandom}, 1'b0);
		queue_row(MODE_ACCUM, '1, '1, 1'b1);
		// writes to tables that do not exist leave the store alone
		queue_write(NUM_TABLES, 0, '1);
		queue_write((1 << SEL_W) - 1, (1 << ENTRY_W) - 1, '1);
		begin
			bus_item_t it;
			it = rand_item();
			it.mode = MODE_UNUSED;
			stim_items.push_back(it);
		end
		// zero entry of every table, then all-zero rows
		for (int t = 0; t < NUM_TABLES; t++)
			queue_write(t, 0, {$urandom, $urandom});
		queue_row(MODE_ASSIGN, '0, '1, 1'b1);
		queue_row(MODE_ACCUM, '0, '1, 1'b0);

		// random: mostly rows over written entries, writes filling the tables,
		// some noise with bad table selects and the unused mode
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			roll = $urandom_range(99);
			if (roll < 30) begin
				queue_write($urandom_range(NUM_TABLES - 1), $urandom_range(ENTRIES - 1),
					rand_row());
			end else if (roll < 33) begin
				queue_write($urandom_range((1 << SEL_W) - 1, NUM_TABLES),
					$urandom_range((1 << ENTRY_W) - 1), rand_row());
			end else if (roll < 36) begin
				bus_item_t it;
				it = rand_item();
				it.mode = MODE_UNUSED;
				stim_items.push_back(it);
			end else begin
				queue_row($urandom_range(1) ? MODE_ACCUM : MODE_ASSIGN,
					row_from_written(), rand_row(), $urandom_range(7) == 0);
			end
		end

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		while (stim_items.size() != 0 || s_tvalid || pending_products.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// hang guard, far beyond the slowest correct run
	initial begin
		#3000000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/gf2fr_pkg.sv
rtl/core/gf2fr_bank.sv
rtl/core/gf2fr_outq.sv
rtl/core/gf2_four_russians_row_multiply.sv
test/testbench.sv
